[sv/rbs_pkg.sv]
// Package for the ray/box slab intersection block.
// Holds the coordinate type, the request and response word structs and the
// pipeline latency of the divider lane. No dependencies.
package rbs_pkg;

   localparam int CoordWidth = 32;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
   } ray_box_req_type;

   typedef struct packed {
      logic      hit;
      coord_type t_near;
      coord_type t_far;
      coord_type near_x;
      coord_type near_y;
      coord_type near_z;
      coord_type far_x;
      coord_type far_y;
      coord_type far_z;
   } ray_box_rsp_type;

   // Input register, one stage per quotient bit, output register.
   function automatic int div_latency(input int w, input int f);
      return w + f + 3;
   endfunction

endpackage

[sv/rbs_div.sv]
// Pipelined restoring divider lane: (num * 2^F) / den, truncated, saturated.
// One quotient bit per stage. Depends on rbs_pkg.
module rbs_div
   import rbs_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W:0]   num,
   input  logic signed [W-1:0] den,
   output logic signed [W-1:0] quo
);

   localparam int N = W + F + 1;
   localparam logic [W:0] VCAP = (W+1)'(1) << (W-1);
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

   logic [W:0]   a_ff    [0:N];
   logic [W-1:0] b_ff    [0:N];
   logic [W-1:0] r_ff    [0:N];
   logic [W:0]   q_ff    [0:N];
   logic         over_ff [0:N];
   logic         neg_ff  [0:N];
   logic [W-1:0] quo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]    <= num[W] ? $unsigned(-num) : $unsigned(num);
         b_ff[0]    <= den[W-1] ? $unsigned(-den) : $unsigned(den);
         r_ff[0]    <= '0;
         q_ff[0]    <= '0;
         over_ff[0] <= 1'b0;
         neg_ff[0]  <= num[W] ^ den[W-1];
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_step
      localparam int I = W + F - j;
      logic         bit_in;
      logic [W:0]   rs;
      logic         ge;
      logic [W:0]   rn;
      logic [W:0]   qn;

      if (I >= F) begin : g_data
         assign bit_in = a_ff[j][I-F];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end

      assign rs = {r_ff[j], bit_in};
      assign ge = rs >= {1'b0, b_ff[j]};
      assign rn = ge ? rs - {1'b0, b_ff[j]} : rs;
      assign qn = {q_ff[j][W-1:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[j+1]   <= a_ff[j];
            b_ff[j+1]   <= b_ff[j];
            r_ff[j+1]   <= rn[W-1:0];
            neg_ff[j+1] <= neg_ff[j];
            if (over_ff[j]) begin
               q_ff[j+1]    <= q_ff[j];
               over_ff[j+1] <= 1'b1;
            end else begin
               q_ff[j+1]    <= qn;
               over_ff[j+1] <= qn > VCAP;
            end
         end
      end
   end

   logic [W:0] qc;
   logic [W:0] qneg;

   assign qc   = over_ff[N] ? VCAP : q_ff[N];
   assign qneg = -qc;

   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[N]) begin
            quo_ff <= qneg[W-1:0];
         end else if (qc >= VCAP) begin
            quo_ff <= VMAX;
         end else begin
            quo_ff <= qc[W-1:0];
         end
      end
   end

   assign quo = $signed(quo_ff);

endmodule

[sv/rbs_slab.sv]
// One axis lane: entry and exit parameters of a slab, ordered, with the
// zero-direction case. Depends on rbs_pkg and rbs_div.
module rbs_slab
   import rbs_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] o,
   input  logic signed [W-1:0] d,
   input  logic signed [W-1:0] mn,
   input  logic signed [W-1:0] mx,
   output logic signed [W-1:0] lo,
   output logic signed [W-1:0] hi,
   output logic                ok,
   output logic signed [W-1:0] o_out,
   output logic signed [W-1:0] d_out
);

   localparam int DL = div_latency(W, F);
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

   logic signed [W:0]   diff_mn;
   logic signed [W:0]   diff_mx;
   logic signed [W-1:0] qa;
   logic signed [W-1:0] qb;

   assign diff_mn = {mn[W-1], mn} - {o[W-1], o};
   assign diff_mx = {mx[W-1], mx} - {o[W-1], o};

   rbs_div #(.W(W), .F(F)) u_div_mn (
      .clock (clock), .en (en), .num (diff_mn), .den (d), .quo (qa)
   );
   rbs_div #(.W(W), .F(F)) u_div_mx (
      .clock (clock), .en (en), .num (diff_mx), .den (d), .quo (qb)
   );

   logic signed [W-1:0] o_ff      [0:DL-1];
   logic signed [W-1:0] d_ff      [0:DL-1];
   logic                zero_ff   [0:DL-1];
   logic                inside_ff [0:DL-1];

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff[0]      <= o;
         d_ff[0]      <= d;
         zero_ff[0]   <= d == '0;
         inside_ff[0] <= (o >= mn) && (o <= mx);
         for (int i = 1; i < DL; i++) begin
            o_ff[i]      <= o_ff[i-1];
            d_ff[i]      <= d_ff[i-1];
            zero_ff[i]   <= zero_ff[i-1];
            inside_ff[i] <= inside_ff[i-1];
         end
      end
   end

   logic signed [W-1:0] lo_ff;
   logic signed [W-1:0] hi_ff;
   logic                ok_ff;
   logic signed [W-1:0] o_out_ff;
   logic signed [W-1:0] d_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         o_out_ff <= o_ff[DL-1];
         d_out_ff <= d_ff[DL-1];
         if (zero_ff[DL-1]) begin
            ok_ff <= inside_ff[DL-1];
            lo_ff <= VMIN;
            hi_ff <= VMAX;
         end else begin
            ok_ff <= 1'b1;
            lo_ff <= (qa > qb) ? qb : qa;
            hi_ff <= (qa > qb) ? qa : qb;
         end
      end
   end

   assign lo    = lo_ff;
   assign hi    = hi_ff;
   assign ok    = ok_ff;
   assign o_out = o_out_ff;
   assign d_out = d_out_ff;

endmodule

[sv/rbs_point.sv]
// Point lane: origin + dir * t with truncation and saturation, two stages.
// Depends on rbs_pkg.
module rbs_point
   import rbs_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] o,
   input  logic signed [W-1:0] d,
   input  logic signed [W-1:0] t,
   output logic signed [W-1:0] p
);

   localparam logic [2*W-1:0] LIM = (2*W)'(1) << (W+1);
   localparam logic signed [W+2:0] VMAX = (W+3)'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [W+2:0] VMIN = -VMAX - (W+3)'(1);

   logic [W-1:0]        dm;
   logic [W-1:0]        tm;
   logic [2*W-1:0]      prod_ff;
   logic                neg_ff;
   logic signed [W-1:0] o_ff;

   assign dm = d[W-1] ? $unsigned(-d) : $unsigned(d);
   assign tm = t[W-1] ? $unsigned(-t) : $unsigned(t);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= dm * tm;
         neg_ff  <= d[W-1] ^ t[W-1];
         o_ff    <= o;
      end
   end

   logic [2*W-1:0]      sh;
   logic [2*W-1:0]      clamped;
   logic signed [W+2:0] pos;
   logic signed [W+2:0] pv;
   logic signed [W+2:0] sum;
   logic signed [W-1:0] p_ff;

   assign sh      = prod_ff >> F;
   assign clamped = (sh > LIM) ? LIM : sh;
   assign pos     = $signed({1'b0, clamped[W+1:0]});
   assign pv      = neg_ff ? -pos : pos;
   assign sum     = {{3{o_ff[W-1]}}, o_ff} + pv;

   always_ff @(posedge clock) begin
      if (en) begin
         if (sum > VMAX) begin
            p_ff <= VMAX[W-1:0];
         end else if (sum < VMIN) begin
            p_ff <= VMIN[W-1:0];
         end else begin
            p_ff <= sum[W-1:0];
         end
      end
   end

   assign p = p_ff;

endmodule

[sv/ray_box_slab_intersection.sv]
// Top level of the ray/box slab intersection block.
// Depends on rbs_pkg, rbs_slab (with rbs_div) and rbs_point.
//
// Usage: each request word carries a ray (origin, direction) and a box
// (min and max corners) in signed Q16.16. Each request gives exactly one
// response word: hit, the entry and exit parameters and the entry and exit
// points. On a miss every field of the response is zero.
// Three axis lanes run side by side; each holds two pipelined dividers that
// produce one quotient bit per stage. A merge stage intersects the three
// intervals, then six multiplier lanes form the entry and exit points.
// Most of the pipeline depth is the divider stages, one per quotient bit, so
// it follows the word width and FRAC_BITS (default Q16.16 format).
// Throughput: one word per cycle while the receiver keeps rsp_ready high.
// When the receiver stalls with a response held, the whole pipeline freezes
// and req_ready drops; req_ready stays high whenever the output register is
// empty or is being taken in the same cycle.
// Reset (synchronous, active high) empties the pipeline; payload registers
// are not cleared. No clearing pass is needed after reset.
module ray_box_slab_intersection
   import rbs_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ray_box_req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ray_box_rsp_type rsp_payload
);

   localparam int W        = CoordWidth;
   localparam int SLAB_LAT = div_latency(W, FRAC_BITS) + 1;
   localparam int LAT      = SLAB_LAT + 3;

   // Valid bits travel beside the data; everything advances together.
   logic valid_ff [0:LAT-1];
   logic en;

   assign en        = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   coord_type o_w  [0:2];
   coord_type d_w  [0:2];
   coord_type mn_w [0:2];
   coord_type mx_w [0:2];

   assign o_w[0]  = req_payload.origin_x;
   assign o_w[1]  = req_payload.origin_y;
   assign o_w[2]  = req_payload.origin_z;
   assign d_w[0]  = req_payload.dir_x;
   assign d_w[1]  = req_payload.dir_y;
   assign d_w[2]  = req_payload.dir_z;
   assign mn_w[0] = req_payload.box_min_x;
   assign mn_w[1] = req_payload.box_min_y;
   assign mn_w[2] = req_payload.box_min_z;
   assign mx_w[0] = req_payload.box_max_x;
   assign mx_w[1] = req_payload.box_max_y;
   assign mx_w[2] = req_payload.box_max_z;

   // Axis lanes.
   coord_type lo_w [0:2];
   coord_type hi_w [0:2];
   logic      ok_w [0:2];
   coord_type so_w [0:2];
   coord_type sd_w [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_slab
      rbs_slab #(.W(W), .F(FRAC_BITS)) u_slab (
         .clock (clock),
         .en    (en),
         .o     (o_w[k]),
         .d     (d_w[k]),
         .mn    (mn_w[k]),
         .mx    (mx_w[k]),
         .lo    (lo_w[k]),
         .hi    (hi_w[k]),
         .ok    (ok_w[k]),
         .o_out (so_w[k]),
         .d_out (sd_w[k])
      );
   end

   // Merge: x interval against y, then the result against z.
   logic      miss_y;
   logic      miss_z;
   coord_type tn_y;
   coord_type tf_y;
   coord_type tn_z;
   coord_type tf_z;
   logic      hit_m;

   assign miss_y = (lo_w[0] > hi_w[1]) || (lo_w[1] > hi_w[0]);
   assign tn_y   = (lo_w[1] > lo_w[0]) ? lo_w[1] : lo_w[0];
   assign tf_y   = (hi_w[1] < hi_w[0]) ? hi_w[1] : hi_w[0];
   assign miss_z = (tn_y > hi_w[2]) || (lo_w[2] > tf_y);
   assign tn_z   = (lo_w[2] > tn_y) ? lo_w[2] : tn_y;
   assign tf_z   = (hi_w[2] < tf_y) ? hi_w[2] : tf_y;
   assign hit_m  = ok_w[0] && ok_w[1] && ok_w[2] && !miss_y && !miss_z;

   logic      hit_m_ff;
   coord_type tn_m_ff;
   coord_type tf_m_ff;
   coord_type o_m_ff [0:2];
   coord_type d_m_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         hit_m_ff <= hit_m;
         tn_m_ff  <= tn_z;
         tf_m_ff  <= tf_z;
         for (int k = 0; k < 3; k++) begin
            o_m_ff[k] <= so_w[k];
            d_m_ff[k] <= sd_w[k];
         end
      end
   end

   // Point lanes: entry and exit point on each axis.
   coord_type pn_w [0:2];
   coord_type pf_w [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_point
      rbs_point #(.W(W), .F(FRAC_BITS)) u_near (
         .clock (clock), .en (en),
         .o (o_m_ff[k]), .d (d_m_ff[k]), .t (tn_m_ff), .p (pn_w[k])
      );
      rbs_point #(.W(W), .F(FRAC_BITS)) u_far (
         .clock (clock), .en (en),
         .o (o_m_ff[k]), .d (d_m_ff[k]), .t (tf_m_ff), .p (pf_w[k])
      );
   end

   // Hit flag and interval follow the two point stages.
   logic      hit_d_ff [0:1];
   coord_type tn_d_ff  [0:1];
   coord_type tf_d_ff  [0:1];

   always_ff @(posedge clock) begin
      if (en) begin
         hit_d_ff[0] <= hit_m_ff;
         tn_d_ff[0]  <= tn_m_ff;
         tf_d_ff[0]  <= tf_m_ff;
         hit_d_ff[1] <= hit_d_ff[0];
         tn_d_ff[1]  <= tn_d_ff[0];
         tf_d_ff[1]  <= tf_d_ff[0];
      end
   end

   // A miss reports zero in every field.
   always_comb begin
      rsp_payload = '0;
      if (hit_d_ff[1]) begin
         rsp_payload.hit    = 1'b1;
         rsp_payload.t_near = tn_d_ff[1];
         rsp_payload.t_far  = tf_d_ff[1];
         rsp_payload.near_x = pn_w[0];
         rsp_payload.near_y = pn_w[1];
         rsp_payload.near_z = pn_w[2];
         rsp_payload.far_x  = pf_w[0];
         rsp_payload.far_y  = pf_w[1];
         rsp_payload.far_z  = pf_w[2];
      end
   end

endmodule

[tb/rbs_checker.sv]
// Checker for the ray/box slab intersection block: watches both channels,
// predicts each response word from the request word and compares them.
// Depends on rbs_pkg.
module rbs_checker
   import rbs_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  ray_box_req_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  ray_box_rsp_type rsp_payload,
   output int              fail_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = CoordWidth;
   localparam longint VMAX = (64'sd1 <<< (W - 1)) - 1;
   localparam longint VMIN = -VMAX - 1;

   ray_box_rsp_type expected_rsps[$];

   function automatic longint clamp(input longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   // Restoring division of (num << FRAC_BITS) by den, truncated and saturated.
   function automatic longint slope_div(input longint num, input longint den);
      logic          neg;
      logic [127:0]  a, b, r, q;
      logic [127:0]  cap;
      logic          over;
      logic [127:0]  bitv;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      cap = 128'd1 << (W - 1);
      r = 0;
      q = 0;
      over = 0;
      for (int i = W + FRAC_BITS; i >= 0; i--) begin
         bitv = (i >= FRAC_BITS) ? ((a >> (i - FRAC_BITS)) & 1) : 0;
         r = (r << 1) | bitv;
         if (r >= b) begin
            r = r - b;
            bitv = 1;
         end else begin
            bitv = 0;
         end
         if (!over) begin
            q = (q << 1) | bitv;
            if (q > cap) over = 1;
         end
      end
      if (over) q = cap;
      if (neg) return -longint'(q);
      return (q >= cap) ? VMAX : longint'(q);
   endfunction

   // Point along the ray: origin + dir * t, product truncated, sum saturated.
   function automatic longint ray_point(input longint o, input longint d, input longint t);
      logic [127:0] prod, lim;
      longint       p;
      prod = 128'((d < 0) ? -d : d) * 128'((t < 0) ? -t : t);
      prod = prod >> FRAC_BITS;
      lim = 128'd1 << (W + 1);
      if (prod > lim) prod = lim;
      p = longint'(prod);
      if ((d < 0) != (t < 0)) p = -p;
      return clamp(o + p);
   endfunction

   function automatic ray_box_rsp_type predict_intersection(input ray_box_req_type rq);
      longint          o[3], d[3], mn[3], mx[3];
      longint          tn, tf, lo, hi, s;
      logic            hit;
      ray_box_rsp_type rs;
      o  = '{rq.origin_x, rq.origin_y, rq.origin_z};
      d  = '{rq.dir_x, rq.dir_y, rq.dir_z};
      mn = '{rq.box_min_x, rq.box_min_y, rq.box_min_z};
      mx = '{rq.box_max_x, rq.box_max_y, rq.box_max_z};
      rs = '0;
      hit = 1;
      tn = 0;
      tf = 0;
      for (int k = 0; k < 3 && hit; k++) begin
         if (d[k] == 0) begin
            if (o[k] < mn[k] || o[k] > mx[k]) begin
               hit = 0;
               break;
            end
            lo = VMIN;
            hi = VMAX;
         end else begin
            lo = slope_div(mn[k] - o[k], d[k]);
            hi = slope_div(mx[k] - o[k], d[k]);
            if (lo > hi) begin
               s = lo;
               lo = hi;
               hi = s;
            end
         end
         if (k == 0) begin
            tn = lo;
            tf = hi;
         end else if (tn > hi || lo > tf) begin
            hit = 0;
         end else begin
            if (lo > tn) tn = lo;
            if (hi < tf) tf = hi;
         end
      end
      if (!hit) return rs;
      rs.hit = 1;
      rs.t_near = coord_type'(tn);
      rs.t_far  = coord_type'(tf);
      rs.near_x = coord_type'(ray_point(o[0], d[0], tn));
      rs.near_y = coord_type'(ray_point(o[1], d[1], tn));
      rs.near_z = coord_type'(ray_point(o[2], d[2], tn));
      rs.far_x  = coord_type'(ray_point(o[0], d[0], tf));
      rs.far_y  = coord_type'(ray_point(o[1], d[1], tf));
      rs.far_z  = coord_type'(ray_point(o[2], d[2], tf));
      return rs;
   endfunction

   task automatic compare_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   initial fail_count = 0;
   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      ray_box_rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_rsps = {expected_rsps, predict_intersection(req_payload)};
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: response word with none expected, actual %h", $time, rsp_payload);
            end else begin
               e = expected_rsps.pop_front();
               compare_field("hit", e.hit, rsp_payload.hit);
               compare_field("t_near", e.t_near, rsp_payload.t_near);
               compare_field("t_far", e.t_far, rsp_payload.t_far);
               compare_field("near_x", e.near_x, rsp_payload.near_x);
               compare_field("near_y", e.near_y, rsp_payload.near_y);
               compare_field("near_z", e.near_z, rsp_payload.near_z);
               compare_field("far_x", e.far_x, rsp_payload.far_x);
               compare_field("far_y", e.far_y, rsp_payload.far_y);
               compare_field("far_z", e.far_z, rsp_payload.far_z);
            end
         end
      end
   end
endmodule

[tb/tb_ray_box_slab_intersection.sv]
// Testbench top for the ray/box slab intersection block: drives request words
// with random idling, stalls the response side and gives the verdict.
// Depends on rbs_pkg, rbs_checker and the block itself.
module tb_ray_box_slab_intersection;
   import rbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int LATENCY = CoordWidth + FRAC + 7;
   // No word accepted on either side for this many cycles means a hang.
   localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;
   localparam int RANDOM_WORDS = 1430;
   localparam int ONE = 32'h0001_0000;

   logic            clock = 0;
   logic            reset = 1;
   logic            req_valid = 0;
   logic            req_ready;
   ray_box_req_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 0;
   ray_box_rsp_type rsp_payload;
   int              fail_count;
   int              pending_count;
   logic            idle_free = 0;
   int              quiet_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   ray_box_slab_intersection #(.FRAC_BITS(FRAC)) i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload
   );

   rbs_checker #(.FRAC_BITS(FRAC)) i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload, .fail_count, .pending_count
   );

   // The receiver stalls in random bursts of random length, except in the
   // closing stretch where it takes every word at once.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (!idle_free && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // The watchdog restarts whenever a word crosses either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ray_box_slab_intersection regression: fail");
         $finish;
      end
   end

   // A random coordinate: mostly modest values near the box, sometimes any bits,
   // sometimes one of the extremes.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return coord_type'($urandom);
         1: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
         2: return 0;
         default: return coord_type'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   // Mostly well-formed boxes (min not above max), sometimes with the origin at
   // the box centre; the rest has zero direction axes or inverted boxes.
   function automatic ray_box_req_type rand_request();
      ray_box_req_type r;
      coord_type       a, b;
      r.origin_x = rand_coord();
      r.origin_y = rand_coord();
      r.origin_z = rand_coord();
      r.dir_x = ($urandom_range(0, 7) == 0) ? 0 : rand_coord();
      r.dir_y = ($urandom_range(0, 7) == 0) ? 0 : rand_coord();
      r.dir_z = ($urandom_range(0, 7) == 0) ? 0 : rand_coord();
      a = rand_coord(); b = rand_coord();
      r.box_min_x = (a < b) ? a : b; r.box_max_x = (a < b) ? b : a;
      a = rand_coord(); b = rand_coord();
      r.box_min_y = (a < b) ? a : b; r.box_max_y = (a < b) ? b : a;
      a = rand_coord(); b = rand_coord();
      r.box_min_z = (a < b) ? a : b; r.box_max_z = (a < b) ? b : a;
      if ($urandom_range(0, 9) == 0) begin
         a = r.box_min_y; r.box_min_y = r.box_max_y; r.box_max_y = a;
      end
      if ($urandom_range(0, 4) == 0) begin
         r.origin_x = r.box_min_x + (r.box_max_x - r.box_min_x) / 2;
         r.origin_y = r.box_min_y + (r.box_max_y - r.box_min_y) / 2;
         r.origin_z = r.box_min_z + (r.box_max_z - r.box_min_z) / 2;
      end
      return r;
   endfunction

   // Holds a word on the request channel until the block takes it, with an
   // optional random idle burst in front.
   task automatic send_word(input ray_box_req_type r);
      int n;
      if (!idle_free && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic ray_box_req_type make_ray(
      input coord_type ox, oy, oz, dx, dy, dz,
      input coord_type lx, ly, lz, hx, hy, hz);
      return '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
   endfunction

   initial begin
      ray_box_req_type directed[$];
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Plain hit along +x through a unit box.
      directed = {directed, make_ray(-2*ONE, ONE/2, ONE/2, ONE, 0, 0,
                                     0, 0, 0, ONE, ONE, ONE)};
      // Negative direction on all axes.
      directed = {directed, make_ray(3*ONE, 3*ONE, 3*ONE, -ONE, -ONE, -ONE,
                                     0, 0, 0, ONE, ONE, ONE)};
      // Miss because the intervals are disjoint.
      directed = {directed, make_ray(-2*ONE, 5*ONE, 0, ONE, 0, ONE,
                                     0, 0, 0, ONE, ONE, ONE)};
      // Zero direction with the origin outside the slab.
      directed = {directed, make_ray(0, 2*ONE, 0, ONE, 0, ONE, 0, 0, 0, ONE, ONE, ONE)};
      // All directions zero, origin inside: unbounded hit.
      directed = {directed, make_ray(ONE/2, ONE/2, ONE/2, 0, 0, 0,
                                     0, 0, 0, ONE, ONE, ONE)};
      // Box behind the ray, but the line misses it in y: a miss.
      directed = {directed, make_ray(5*ONE, ONE/2, ONE/2, ONE, ONE/4, 0,
                                     0, 0, 0, ONE, ONE, ONE)};
      // Inverted box with nonzero and with zero direction.
      directed = {directed, make_ray(-ONE, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0)};
      directed = {directed, make_ray(0, 0, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE)};
      // Tiny direction forces quotient saturation; huge values saturate points.
      directed = {directed, make_ray(32'sh8000_0000, 0, 0, 1, 1, 1,
                                     32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff)};
      directed = {directed, make_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff)};
      directed = {directed, make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1)};
      directed = {directed, make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh7fff_ffff, -1, 32'sh8000_0000, 0, 0, 0,
                                     32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff)};
      // Origin exactly on the slab faces with zero direction.
      directed = {directed, make_ray(0, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE)};
      foreach (directed[i]) send_word(directed[i]);

      // Hold off until every response is back, then start the random part.
      req_valid <= 0;
      wait (pending_count == 0);
      @(posedge clock);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - 200) idle_free = 1;
         send_word(rand_request());
      end
      req_valid <= 0;

      wait (pending_count == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("ray_box_slab_intersection regression: pass");
      else
         $display("ray_box_slab_intersection regression: fail");
      $finish;
   end
endmodule
